>>> sv/qmr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the quaternion multiply/rotate unit.
// Used by every module of the block; depends on nothing.
package qmr_pkg;

   localparam int WORD_BITS = 32;

   typedef logic signed [WORD_BITS-1:0] word_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam word_type WORD_ZERO = '0;

   typedef enum logic [1:0] {
      FUNC_MUL    = 2'd0,
      FUNC_CONJ   = 2'd1,
      FUNC_ROT    = 2'd2,
      FUNC_UNUSED = 2'd3
   } func_type;

   typedef struct packed {
      word_type r;
      word_type i;
      word_type j;
      word_type k;
   } quat_type;

   typedef struct packed {
      logic [1:0] func;
      word_type   a_r;
      word_type   a_i;
      word_type   a_j;
      word_type   a_k;
      word_type   b_r;
      word_type   b_i;
      word_type   b_j;
      word_type   b_k;
   } req_type;

   typedef struct packed {
      word_type res_r;
      word_type res_i;
      word_type res_j;
      word_type res_k;
      logic     overflow;
   } rsp_type;

   typedef struct packed {
      logic [1:0] func;
      quat_type   a;
      quat_type   c;
      logic       ovc;
      quat_type   t1;
      logic       ov1;
   } side_type;

endpackage
`default_nettype wire

>>> sv/qmr_prep.sv
`timescale 1ns / 1ps
`default_nettype none
// Input stage: saturating conjugate of a and operand select for the first product.
// Depends on qmr_pkg.
module qmr_prep (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire qmr_pkg::req_type  in_data,
   output logic                   out_valid,
   output qmr_pkg::quat_type      out_x,
   output qmr_pkg::quat_type      out_y,
   output qmr_pkg::side_type      out_side
);
   import qmr_pkg::*;

   logic     valid_ff;
   quat_type x_ff, x_in;
   quat_type y_ff, y_in;
   side_type side_ff, side_in;

   function automatic word_type sneg(input word_type v);
      return (v == WORD_MIN) ? WORD_MAX : -v;
   endfunction

   always_comb begin
      quat_type a, b, c;
      a = '{in_data.a_r, in_data.a_i, in_data.a_j, in_data.a_k};
      b = '{in_data.b_r, in_data.b_i, in_data.b_j, in_data.b_k};
      c = '{in_data.a_r, sneg(in_data.a_i), sneg(in_data.a_j), sneg(in_data.a_k)};
      side_in      = '0;
      side_in.func = in_data.func;
      side_in.a    = a;
      side_in.c    = c;
      side_in.ovc  = (in_data.a_i == WORD_MIN) || (in_data.a_j == WORD_MIN) ||
                     (in_data.a_k == WORD_MIN);
      if (in_data.func == FUNC_ROT) begin
         x_in = '{WORD_ZERO, in_data.b_i, in_data.b_j, in_data.b_k};
         y_in = c;
      end else begin
         x_in = a;
         y_in = b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      side_ff <= side_in;
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_side  = side_ff;

endmodule
`default_nettype wire

>>> sv/qmr_qmul.sv
`timescale 1ns / 1ps
`default_nettype none
// Three-stage Hamilton product x*y: sixteen products, pair sums, final sum and saturate.
// Depends on qmr_pkg.
module qmr_qmul #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire qmr_pkg::quat_type  in_x,
   input  wire qmr_pkg::quat_type  in_y,
   input  wire qmr_pkg::side_type  in_side,
   output logic                    out_valid,
   output qmr_pkg::quat_type       out_z,
   output logic                    out_ov,
   output qmr_pkg::side_type       out_side
);
   import qmr_pkg::*;

   localparam int PROD_W = 2 * WORD_BITS;
   localparam int TERM_W = PROD_W - FRAC_BITS;
   localparam int PAIR_W = TERM_W + 1;
   localparam int SUM_W  = TERM_W + 2;

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [TERM_W-1:0] term_type;
   typedef logic signed [PAIR_W-1:0] pair_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   logic     v1_ff, v2_ff, v3_ff;
   side_type side1_ff, side2_ff, side3_ff;
   prod_type prod_ff [16];
   prod_type prod_in [16];
   pair_type pa_ff [4];
   pair_type pb_ff [4];
   pair_type pa_in [4];
   pair_type pb_in [4];
   quat_type z_ff, z_in;
   logic     ov_ff, ov_in;

   // stage 1: all sixteen exact products
   always_comb begin
      word_type xa [4];
      word_type ya [4];
      xa = '{in_x.r, in_x.i, in_x.j, in_x.k};
      ya = '{in_y.r, in_y.i, in_y.j, in_y.k};
      for (int m = 0; m < 4; m++) begin
         for (int n = 0; n < 4; n++) begin
            prod_in[4*m+n] = PROD_W'(xa[m]) * PROD_W'(ya[n]);
         end
      end
   end

   // stage 2: floor shift and pair sums; term index is 4*x_part + y_part
   always_comb begin
      pair_type t [16];
      for (int n = 0; n < 16; n++) begin
         t[n] = PAIR_W'(term_type'(prod_ff[n][PROD_W-1:FRAC_BITS]));
      end
      pa_in[0] = t[0]  - t[5];
      pb_in[0] = t[10] + t[15];
      pa_in[1] = t[4]  + t[1];
      pb_in[1] = t[11] - t[14];
      pa_in[2] = t[8]  + t[13];
      pb_in[2] = t[2]  - t[7];
      pa_in[3] = t[12] - t[9];
      pb_in[3] = t[6]  + t[3];
   end

   // stage 3: final sum and saturate
   always_comb begin
      sum_type  s;
      word_type za [4];
      ov_in = 1'b0;
      for (int n = 0; n < 4; n++) begin
         if (n == 0) begin
            s = SUM_W'(pa_ff[n]) - SUM_W'(pb_ff[n]);
         end else begin
            s = SUM_W'(pa_ff[n]) + SUM_W'(pb_ff[n]);
         end
         if (s > SUM_W'(WORD_MAX)) begin
            za[n] = WORD_MAX;
            ov_in = 1'b1;
         end else if (s < SUM_W'(WORD_MIN)) begin
            za[n] = WORD_MIN;
            ov_in = 1'b1;
         end else begin
            za[n] = s[WORD_BITS-1:0];
         end
      end
      z_in = '{za[0], za[1], za[2], za[3]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      side1_ff <= in_side;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      side2_ff <= side1_ff;
      z_ff     <= z_in;
      ov_ff    <= ov_in;
      side3_ff <= side2_ff;
   end

   assign out_valid = v3_ff;
   assign out_z     = z_ff;
   assign out_ov    = ov_ff;
   assign out_side  = side3_ff;

endmodule
`default_nettype wire

>>> sv/quaternion_multiply_rotate.sv
`timescale 1ns / 1ps
`default_nettype none
// Quaternion unit, signed fixed point: Hamilton product, conjugate, vector rotation.
// Top level; depends on qmr_pkg, qmr_prep and qmr_qmul.
//
// One item is taken in every cycle and its result appears on rsp_data with
// rsp_strobe after the prep stage, two three-stage product pipelines in
// series and the output register. busy stays low: the pipeline never
// stalls and the receiver must take each result beat in the cycle it is
// shown. Rotation runs v*conj(a) through the first product pipeline and
// a*t through the second; multiply uses the first only.
module quaternion_multiply_rotate #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire qmr_pkg::req_type  req_data,
   output logic                   rsp_strobe,
   output qmr_pkg::rsp_type       rsp_data
);
   import qmr_pkg::*;

   localparam int LATENCY = 8;

   logic     p_valid, q1_valid, q2_valid;
   quat_type p_x, p_y, q1_z, q2_z;
   side_type p_side, q1_side, q2_in_side, q2_side;
   logic     q1_ov, q2_ov;

   logic     strobe_ff;
   rsp_type  rsp_ff, rsp_in;

   assign busy = 1'b0;

   qmr_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .out_valid (p_valid),
      .out_x     (p_x),
      .out_y     (p_y),
      .out_side  (p_side)
   );

   qmr_qmul #(.FRAC_BITS(FRAC_BITS)) u_qmul_first (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid),
      .in_x      (p_x),
      .in_y      (p_y),
      .in_side   (p_side),
      .out_valid (q1_valid),
      .out_z     (q1_z),
      .out_ov    (q1_ov),
      .out_side  (q1_side)
   );

   always_comb begin
      q2_in_side     = q1_side;
      q2_in_side.t1  = q1_z;
      q2_in_side.ov1 = q1_ov;
   end

   qmr_qmul #(.FRAC_BITS(FRAC_BITS)) u_qmul_second (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q1_valid),
      .in_x      (q1_side.a),
      .in_y      (q1_z),
      .in_side   (q2_in_side),
      .out_valid (q2_valid),
      .out_z     (q2_z),
      .out_ov    (q2_ov),
      .out_side  (q2_side)
   );

   always_comb begin
      rsp_in = '0;
      case (q2_side.func)
         FUNC_MUL: begin
            rsp_in = '{q2_side.t1.r, q2_side.t1.i, q2_side.t1.j, q2_side.t1.k,
                       q2_side.ov1};
         end
         FUNC_CONJ: begin
            rsp_in = '{q2_side.c.r, q2_side.c.i, q2_side.c.j, q2_side.c.k,
                       q2_side.ovc};
         end
         FUNC_ROT: begin
            rsp_in = '{WORD_ZERO, q2_z.i, q2_z.j, q2_z.k,
                       q2_side.ovc | q2_side.ov1 | q2_ov};
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= q2_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("accepted beat produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LATENCY))
      else $error("result beat without an accepted item");

   a_rot_real_zero: assert property (@(posedge clock) disable iff (reset)
      (q2_valid && q2_side.func == FUNC_ROT) |=> (rsp_data.res_r == WORD_ZERO))
      else $error("rotate result has nonzero real part");

   a_unused_code: assert property (@(posedge clock) disable iff (reset)
      (q2_valid && q2_side.func == FUNC_UNUSED) |=> (rsp_data == '0))
      else $error("unused operation code gave nonzero result");

endmodule
`default_nettype wire

>>> verif/qmr_checker.sv
`timescale 1ns / 1ps
// Result checker for the quaternion multiply/rotate unit: predicts each accepted request beat
// and compares every result beat, in order, with the oldest prediction. Depends on qmr_pkg.
module qmr_checker #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire qmr_pkg::req_type  req_data,
   input  wire logic              rsp_strobe,
   input  wire qmr_pkg::rsp_type  rsp_data,
   output int                     mismatch_count,
   output int                     pending_count
);
   import qmr_pkg::*;

   rsp_type predicted_q[$];
   int      errors = 0;

   function automatic longint fx_term(input word_type x, input word_type y);
      longint prod;
      prod = longint'(x) * longint'(y);
      return prod >>> FRAC_BITS;
   endfunction

   function automatic word_type clamp_word(input longint sum, inout logic ovf);
      if (sum > longint'(WORD_MAX)) begin
         ovf = 1'b1;
         return WORD_MAX;
      end
      if (sum < longint'(WORD_MIN)) begin
         ovf = 1'b1;
         return WORD_MIN;
      end
      return word_type'(sum);
   endfunction

   function automatic word_type neg_sat(input word_type x, inout logic ovf);
      if (x == WORD_MIN) begin
         ovf = 1'b1;
         return WORD_MAX;
      end
      return -x;
   endfunction

   function automatic quat_type hamilton(input quat_type a, input quat_type b, inout logic ovf);
      quat_type p;
      p.r = clamp_word(fx_term(a.r, b.r) - fx_term(a.i, b.i)
                       - fx_term(a.j, b.j) - fx_term(a.k, b.k), ovf);
      p.i = clamp_word(fx_term(a.i, b.r) + fx_term(a.r, b.i)
                       - fx_term(a.k, b.j) + fx_term(a.j, b.k), ovf);
      p.j = clamp_word(fx_term(a.j, b.r) + fx_term(a.k, b.i)
                       + fx_term(a.r, b.j) - fx_term(a.i, b.k), ovf);
      p.k = clamp_word(fx_term(a.k, b.r) - fx_term(a.j, b.i)
                       + fx_term(a.i, b.j) + fx_term(a.r, b.k), ovf);
      return p;
   endfunction

   function automatic rsp_type quat_unit_result(input req_type q);
      quat_type a;
      quat_type b;
      quat_type v;
      quat_type c;
      quat_type t1;
      quat_type t2;
      logic     ovf;
      rsp_type  res;
      a.r = q.a_r; a.i = q.a_i; a.j = q.a_j; a.k = q.a_k;
      b.r = q.b_r; b.i = q.b_i; b.j = q.b_j; b.k = q.b_k;
      res = '0;
      ovf = 1'b0;
      case (q.func)
         FUNC_MUL: begin
            t1 = hamilton(a, b, ovf);
            res.res_r = t1.r;
            res.res_i = t1.i;
            res.res_j = t1.j;
            res.res_k = t1.k;
         end
         FUNC_CONJ: begin
            res.res_r = a.r;
            res.res_i = neg_sat(a.i, ovf);
            res.res_j = neg_sat(a.j, ovf);
            res.res_k = neg_sat(a.k, ovf);
         end
         FUNC_ROT: begin
            v.r = WORD_ZERO; v.i = q.b_i; v.j = q.b_j; v.k = q.b_k;
            c.r = a.r;
            c.i = neg_sat(a.i, ovf);
            c.j = neg_sat(a.j, ovf);
            c.k = neg_sat(a.k, ovf);
            t1 = hamilton(v, c, ovf);
            t2 = hamilton(a, t1, ovf);
            res.res_i = t2.i;
            res.res_j = t2.j;
            res.res_k = t2.k;
         end
         default: ;
      endcase
      res.overflow = ovf;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (predicted_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: result beat with none expected: r=%h i=%h j=%h k=%h ov=%b",
                        $time, rsp_data.res_r, rsp_data.res_i, rsp_data.res_j,
                        rsp_data.res_k, rsp_data.overflow);
         end else begin
            want = predicted_q.pop_front();
            if (want.res_r !== rsp_data.res_r || want.res_i !== rsp_data.res_i ||
                want.res_j !== rsp_data.res_j || want.res_k !== rsp_data.res_k ||
                want.overflow !== rsp_data.overflow) begin
               errors++;
               if (errors <= 10) begin
                  $write("%0t: mismatch: expected r=%h i=%h j=%h k=%h ov=%b,",
                         $time, want.res_r, want.res_i, want.res_j, want.res_k,
                         want.overflow);
                  $display(" got r=%h i=%h j=%h k=%h ov=%b",
                           rsp_data.res_r, rsp_data.res_i, rsp_data.res_j,
                           rsp_data.res_k, rsp_data.overflow);
               end
            end
         end
      end
      if (!reset && start && !busy)
         predicted_q.push_back(quat_unit_result(req_data));
      mismatch_count <= errors;
      pending_count <= predicted_q.size();
   end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Top of the quaternion multiply/rotate testbench: clock, reset, directed and random request
// beats with idle phases, and the verdict. Depends on qmr_pkg, the block and qmr_checker.
module tb_top;
   import qmr_pkg::*;

   localparam int         FRAC_BITS   = 16;
   localparam word_type   ONE         = 32'sh0001_0000;
   localparam word_type   HALF        = 32'sh0000_8000;
   localparam word_type   C45         = 32'sd46341;
   localparam word_type   ALL_ONES    = -32'sd1;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      mismatch_count;
   int      pending_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   quaternion_multiply_rotate #(
      .FRAC_BITS(FRAC_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   qmr_checker #(
      .FRAC_BITS(FRAC_BITS)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .mismatch_count(mismatch_count),
      .pending_count(pending_count)
   );

   function automatic req_type make_req(input logic [1:0] func,
                                        input word_type ar, input word_type ai,
                                        input word_type aj, input word_type ak,
                                        input word_type br, input word_type bi,
                                        input word_type bj, input word_type bk);
      req_type q;
      q.func = func;
      q.a_r = ar; q.a_i = ai; q.a_j = aj; q.a_k = ak;
      q.b_r = br; q.b_i = bi; q.b_j = bj; q.b_k = bk;
      return q;
   endfunction

   function automatic word_type pick_word();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return word_type'(int'($urandom_range(0, 'h60000)) - 'h30000);
         5, 6, 7:       return word_type'($urandom);
         8: begin
            case ($urandom_range(0, 6))
               0:       return WORD_MIN;
               1:       return WORD_MAX;
               2:       return WORD_ZERO;
               3:       return ALL_ONES;
               4:       return 32'sd1;
               5:       return ONE;
               default: return -ONE;
            endcase
         end
         default:       return word_type'(int'($urandom) >>> 7);
      endcase
   endfunction

   function automatic quat_type unit_quat();
      quat_type u;
      case ($urandom_range(0, 6))
         0:       u = '{r: ONE,  i: 0,    j: 0,    k: 0};
         1:       u = '{r: C45,  i: 0,    j: 0,    k: C45};
         2:       u = '{r: C45,  i: C45,  j: 0,    k: 0};
         3:       u = '{r: C45,  i: 0,    j: C45,  k: 0};
         4:       u = '{r: 0,    i: ONE,  j: 0,    k: 0};
         5:       u = '{r: HALF, i: HALF, j: HALF, k: HALF};
         default: u = '{r: 0,    i: 0,    j: 0,    k: ONE};
      endcase
      if ($urandom_range(0, 1)) u.r = -u.r;
      if ($urandom_range(0, 1)) u.i = -u.i;
      if ($urandom_range(0, 1)) u.j = -u.j;
      if ($urandom_range(0, 1)) u.k = -u.k;
      return u;
   endfunction

   function automatic req_type random_req();
      req_type  q;
      quat_type u;
      int       sel;
      sel = $urandom_range(0, 99);
      q = make_req(FUNC_MUL, pick_word(), pick_word(), pick_word(), pick_word(),
                   pick_word(), pick_word(), pick_word(), pick_word());
      if (sel < 40)
         q.func = FUNC_MUL;
      else if (sel < 60)
         q.func = FUNC_CONJ;
      else if (sel < 95)
         q.func = FUNC_ROT;
      else
         q.func = FUNC_UNUSED;
      // rotate mostly by a unit quaternion so the result stays meaningful
      if (q.func == FUNC_ROT && $urandom_range(0, 9) < 6) begin
         u = unit_quat();
         q.a_r = u.r; q.a_i = u.i; q.a_j = u.j; q.a_k = u.k;
      end
      return q;
   endfunction

   task automatic send_beat(input req_type beat);
      req_data <= beat;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_gap(input int pct);
      if ($urandom_range(1, 100) <= pct) begin
         start <= 1'b0;
         req_data <= random_req();
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      int idle_pct;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_beat(make_req(FUNC_MUL, 0, 0, 0, 0, 0, 0, 0, 0));
      send_beat(make_req(FUNC_MUL, ONE, 0, 0, 0,
                         32'sh0001_8000, -32'sh0002_4000, 32'sh0003_0000, -HALF));
      send_beat(make_req(FUNC_MUL, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                         WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
      send_beat(make_req(FUNC_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                         WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
      send_beat(make_req(FUNC_MUL, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX,
                         WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN));
      // floor rounding of a tiny negative product
      send_beat(make_req(FUNC_MUL, ALL_ONES, 0, 0, 0, 32'sd1, 0, 0, 0));
      send_beat(make_req(FUNC_MUL, 0, ONE, 0, 0, 0, 0, ONE, 0));
      send_beat(make_req(FUNC_MUL, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                         ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
      send_beat(make_req(FUNC_MUL, 32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555,
                         32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
                         32'shAAAA_AAAA, 32'shAAAA_AAAA));
      send_beat(make_req(FUNC_CONJ, 32'sh0001_2345, -32'sh0000_6789, 32'sh0007_0000, ONE,
                         0, 0, 0, 0));
      // negating the most negative word saturates
      send_beat(make_req(FUNC_CONJ, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                         WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
      send_beat(make_req(FUNC_CONJ, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 0, 0, 0, 0));
      send_beat(make_req(FUNC_CONJ, 0, 0, WORD_MIN, 0, 0, 0, 0, 0));
      send_beat(make_req(FUNC_ROT, ONE, 0, 0, 0,
                         0, ONE, 32'sh0002_0000, 32'sh0003_0000));
      send_beat(make_req(FUNC_ROT, C45, 0, 0, C45, 0, ONE, 0, 0));
      send_beat(make_req(FUNC_ROT, HALF, HALF, HALF, HALF,
                         WORD_MAX, ONE, 32'sh0002_0000, 32'sh0003_0000));
      // conjugate inside rotate saturates
      send_beat(make_req(FUNC_ROT, ONE, WORD_MIN, 0, 0, 0, ONE, ONE, ONE));
      // intermediate product saturates before the second multiply
      send_beat(make_req(FUNC_ROT, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                         WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
      send_beat(make_req(FUNC_ROT, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                         WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
      send_beat(make_req(FUNC_ROT, 32'sh0012_3456, -32'sh0000_789A, 32'sh0003_0000,
                         -ONE, 0, 0, 0, 0));
      send_beat(make_req(FUNC_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                         ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
      send_beat(make_req(FUNC_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0));

      for (int phase = 0; phase < 6; phase++) begin
         case (phase % 3)
            0:       idle_pct = 0;
            1:       idle_pct = 68;
            default: idle_pct = 13;
         endcase
         for (int n = 0; n < 160; n++) begin
            idle_gap(idle_pct);
            send_beat(random_req());
         end
      end
      start <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin : watchdog
      #1_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
